// ===== rtl/weam_pkg.sv =====
// shared types and constants for the windowed event activity monitor
package weam_pkg;

  localparam int CNT_W     = 16;
  localparam int TIME_W    = 32;
  localparam int THR_W     = 16;
  localparam int FRAC_W    = 17;
  localparam int DIV_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int IN_USER_W = 3;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 216;

  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};
  localparam logic [FRAC_W-1:0] FULL_SCALE = 17'h10000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OCC_WIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_WIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DENSE_THR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_THR  = 3'd4;

  localparam logic [TIME_W-1:0] OCC_WIN_RST   = 32'd1000;
  localparam logic [TIME_W-1:0] PAT_WIN_RST   = 32'd1000;
  localparam logic [THR_W-1:0]  QUIET_THR_RST = 16'd0;
  localparam logic [THR_W-1:0]  DENSE_THR_RST = 16'd8;
  localparam logic [THR_W-1:0]  BUSY_THR_RST  = 16'd8;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_RAW  = 2'd1,
    ACT_INSP = 2'd2,
    ACT_PAT  = 2'd3
  } action_t;

  // packed msb first, so the first output field lands in the lowest bits
  typedef struct packed {
    logic [TIME_W-1:0] last_pattern_time;
    logic [TIME_W-1:0] last_inspected_time;
    logic [TIME_W-1:0] last_occurrence_time;
    logic [DIV_W-1:0]  noise_floor;
    logic [FRAC_W-1:0] density_level;
    logic [FRAC_W-1:0] activity_level;
    logic              is_dense;
    logic              is_active;
    logic              is_quiet;
    logic [CNT_W-1:0]  pattern_count;
    logic [CNT_W-1:0]  accepted_count;
    logic [CNT_W-1:0]  occurrence_count;
  } result_t;

endpackage

// ===== rtl/windowed_event_activity_monitor.sv =====
// top level of the windowed event activity monitor
//
// input channel: one transaction per tick or event; in_tdata carries the
// millisecond timestamp, in_tuser the action code and the event flag.
// a tick rolls the occurrence and pattern windows, a flagged event bumps its
// saturating counter and records its timestamp; both recompute the result.
// an event with its flag clear repeats the previous result unchanged.
// output channel: one result transaction per input transaction, in order.
// the three fractions (activity, density, noise floor) come from three
// bit-serial restoring dividers running side by side, one quotient bit per
// cycle. a recomputed result goes through the load and calc states to the
// emit state and then into the output register; a repeated result goes
// from idle straight to the emit state and then into the output register.
// one item is in flight at a time; in_tready is high only while idle.
// the finished result sits in an output register, so the next item is taken
// while a stalled receiver still holds the previous result; the block only
// waits before loading the output register until that slot frees up.
// configuration writes take effect at once and are meant for idle periods.
// synchronous active-low reset restores the default register values, clears
// counters, window starts, timestamps and the stored result (all zero).
module windowed_event_activity_monitor (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [weam_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [weam_pkg::CFG_W-1:0]       cfg_wdata,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [weam_pkg::IN_DATA_W-1:0]   in_tdata,   // now_ms[31:0]
  input  logic [weam_pkg::IN_USER_W-1:0]   in_tuser,   // action[1:0], event_flag[2]
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // occurrence_count[15:0], accepted_count[31:16], pattern_count[47:32],
  // is_quiet[48], is_active[49], is_dense[50], activity_level[67:51],
  // density_level[84:68], noise_floor[116:85], last_occurrence_time[148:117],
  // last_inspected_time[180:149], last_pattern_time[212:181], zero pad[215:213]
  output logic [weam_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import weam_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_CALC,
    S_EMIT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [TIME_W-1:0] occ_win_r;
  logic [TIME_W-1:0] pat_win_r;
  logic [THR_W-1:0]  quiet_thr_r;
  logic [THR_W-1:0]  dense_thr_r;
  logic [THR_W-1:0]  busy_thr_r;

  // monitor state
  logic [CNT_W-1:0]  occ_cnt_r;
  logic [CNT_W-1:0]  acc_cnt_r;
  logic [CNT_W-1:0]  pat_cnt_r;
  logic [TIME_W-1:0] occ_start_r;
  logic [TIME_W-1:0] pat_start_r;
  logic [TIME_W-1:0] occ_stamp_r;
  logic [TIME_W-1:0] insp_stamp_r;
  logic [TIME_W-1:0] pat_stamp_r;
  result_t           res_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // input decode
  action_t           in_action;
  logic              in_flag;
  logic [TIME_W-1:0] in_now;
  logic              in_fire;

  assign in_action = action_t'(in_tuser[1:0]);
  assign in_flag   = in_tuser[2];
  assign in_now    = in_tdata;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // window expiry: a timestamp below the start never closes the window
  logic [TIME_W-1:0] occ_age;
  logic [TIME_W-1:0] pat_age;
  logic              occ_expired;
  logic              pat_expired;

  assign occ_age     = in_now - occ_start_r;
  assign pat_age     = in_now - pat_start_r;
  assign occ_expired = (in_now >= occ_start_r) && (occ_age >= occ_win_r);
  assign pat_expired = (in_now >= pat_start_r) && (pat_age >= pat_win_r);

  // serial dividers: noise floor, activity and density
  logic             div_start;
  logic             noise_busy;
  logic             act_busy;
  logic             den_busy;
  logic [DIV_W-1:0] noise_quo;
  logic [DIV_W-1:0] act_quo;
  logic [DIV_W-1:0] den_quo;

  assign div_start = (state_r == S_LOAD);

  // a zero window gives an all-ones quotient, which is the saturated value
  weam_sdiv u_noise_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({occ_cnt_r, 16'h0000}),
    .divisor  (occ_win_r),
    .busy     (noise_busy),
    .quotient (noise_quo)
  );

  weam_sdiv u_act_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({occ_cnt_r, 16'h0000}),
    .divisor  ({16'h0000, busy_thr_r}),
    .busy     (act_busy),
    .quotient (act_quo)
  );

  weam_sdiv u_den_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({pat_cnt_r, 16'h0000}),
    .divisor  ({16'h0000, dense_thr_r}),
    .busy     (den_busy),
    .quotient (den_quo)
  );

  // result assembly once the dividers are through
  result_t           res_calc;
  logic [FRAC_W-1:0] act_level;
  logic [FRAC_W-1:0] den_level;
  logic [DIV_W-1:0]  noise_level;
  logic              div_busy;

  assign div_busy = noise_busy || act_busy || den_busy;

  always_comb begin
    // below full scale the quotient stays under 2^16
    if (occ_cnt_r == '0) begin
      act_level = '0;
    end else if (occ_cnt_r >= busy_thr_r) begin
      act_level = FULL_SCALE;
    end else begin
      act_level = {1'b0, act_quo[15:0]};
    end

    if (pat_cnt_r == '0) begin
      den_level = '0;
    end else if (pat_cnt_r >= dense_thr_r) begin
      den_level = FULL_SCALE;
    end else begin
      den_level = {1'b0, den_quo[15:0]};
    end

    noise_level = (occ_cnt_r == '0) ? '0 : noise_quo;

    res_calc.occurrence_count     = occ_cnt_r;
    res_calc.accepted_count       = acc_cnt_r;
    res_calc.pattern_count        = pat_cnt_r;
    res_calc.is_quiet             = (occ_cnt_r <= quiet_thr_r);
    res_calc.is_active            = (occ_cnt_r != '0);
    res_calc.is_dense             = (occ_cnt_r >= dense_thr_r);
    res_calc.activity_level       = act_level;
    res_calc.density_level        = den_level;
    res_calc.noise_floor          = noise_level;
    res_calc.last_occurrence_time = occ_stamp_r;
    res_calc.last_inspected_time  = insp_stamp_r;
    res_calc.last_pattern_time    = pat_stamp_r;
  end

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occ_win_r    <= OCC_WIN_RST;
      pat_win_r    <= PAT_WIN_RST;
      quiet_thr_r  <= QUIET_THR_RST;
      dense_thr_r  <= DENSE_THR_RST;
      busy_thr_r   <= BUSY_THR_RST;
      occ_cnt_r    <= '0;
      acc_cnt_r    <= '0;
      pat_cnt_r    <= '0;
      occ_start_r  <= '0;
      pat_start_r  <= '0;
      occ_stamp_r  <= '0;
      insp_stamp_r <= '0;
      pat_stamp_r  <= '0;
      res_r        <= '0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
    end else begin
      // configuration writes, indexes past the list are dropped
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OCC_WIN:   occ_win_r   <= cfg_wdata;
          REG_PAT_WIN:   pat_win_r   <= cfg_wdata;
          REG_QUIET_THR: quiet_thr_r <= cfg_wdata[THR_W-1:0];
          REG_DENSE_THR: dense_thr_r <= cfg_wdata[THR_W-1:0];
          REG_BUSY_THR:  busy_thr_r  <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end

      // a new result loads the slot, else the receiver took the held result
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_action == ACT_TICK) begin
              // zero start means the window has not opened yet
              if (occ_start_r == '0) begin
                occ_start_r <= in_now;
              end else if (occ_expired) begin
                occ_cnt_r   <= '0;
                acc_cnt_r   <= '0;
                occ_start_r <= in_now;
              end
              if (pat_start_r == '0) begin
                pat_start_r <= in_now;
              end else if (pat_expired) begin
                pat_cnt_r   <= '0;
                pat_start_r <= in_now;
              end
              state_r <= S_LOAD;
            end else if (in_flag) begin
              unique case (in_action)
                ACT_RAW: begin
                  occ_stamp_r <= in_now;
                  if (occ_cnt_r != CNT_MAX) occ_cnt_r <= occ_cnt_r + 1'b1;
                end
                ACT_INSP: begin
                  insp_stamp_r <= in_now;
                  if (acc_cnt_r != CNT_MAX) acc_cnt_r <= acc_cnt_r + 1'b1;
                end
                ACT_PAT: begin
                  pat_stamp_r <= in_now;
                  if (pat_cnt_r != CNT_MAX) pat_cnt_r <= pat_cnt_r + 1'b1;
                end
                default: ;
              endcase
              state_r <= S_LOAD;
            end else begin
              // flag clear: repeat the stored result
              state_r <= S_EMIT;
            end
          end
        end
        S_LOAD: begin
          state_r <= S_CALC;
        end
        S_CALC: begin
          if (!div_busy) begin
            res_r   <= res_calc;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_data_r  <= {3'b000, res_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/weam_sdiv.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module weam_sdiv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [weam_pkg::DIV_W-1:0] dividend,
  input  logic [weam_pkg::DIV_W-1:0] divisor,
  output logic                      busy,
  output logic [weam_pkg::DIV_W-1:0] quotient
);
  import weam_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]    rem_r;
  logic [DIV_W-1:0]    quo_r;
  logic [DIV_W-1:0]    den_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;

  logic [DIV_W:0]   trial;
  logic             take;
  logic [DIV_W:0]   diff;
  logic [DIV_W-1:0] rem_nxt;

  // shift the next dividend bit into the partial remainder and try a subtract
  assign trial   = {rem_r, quo_r[DIV_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign take    = (trial >= {1'b0, den_r});
  assign rem_nxt = take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_BITS'(DIV_W);
      rem_r  <= '0;
      quo_r  <= dividend;
      den_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], take};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
